### sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/sfd_pkg.sv
// Types and constants of the serial frame deframer.
// Used by sfd_parser and the top level; depends on nothing.
`default_nettype none

package sfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'hAA;
  localparam logic [ByteW-1:0] EndMarkerRst = 8'hBB;
  localparam logic [ByteW-1:0] MaxPayloadRst = 8'hFF;

  localparam logic [CfgIdxW-1:0] RegStartMarker = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEndMarker = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxPayload = 2'd2;

  typedef enum logic [2:0] {
    KindNone   = 3'd0,
    KindHeader = 3'd1,
    KindData   = 3'd2,
    KindAccept = 3'd3,
    KindReject = 3'd4
  } kind_e;

  typedef enum logic [5:0] {
    PhIdle    = 6'b000001,
    PhLen     = 6'b000010,
    PhId      = 6'b000100,
    PhPayload = 6'b001000,
    PhCheck   = 6'b010000,
    PhEnd     = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
    logic [ByteW-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] frame_id;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] payload_pos;
    logic [ByteW-1:0] data_byte;
  } res_t;

endpackage

`default_nettype wire

### sv/sfd_parser.sv
// Frame parser: holds the frame state and forms the result of one byte.
// Depends on sfd_pkg.
`default_nettype none

module sfd_parser (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire logic [sfd_pkg::ByteW-1:0] byte_i,
  input  wire sfd_pkg::cfg_t           cfg_i,
  output sfd_pkg::res_t                res_o
);

  sfd_pkg::phase_e phase_q, phase_d;
  logic [sfd_pkg::ByteW-1:0] count_q, count_d;
  logic [sfd_pkg::ByteW-1:0] len_q, len_d;
  logic [sfd_pkg::ByteW-1:0] id_q, id_d;
  logic [sfd_pkg::ByteW-1:0] xor_q, xor_d;
  logic [sfd_pkg::ByteW-1:0] chk_q, chk_d;
  logic [sfd_pkg::ByteW-1:0] count_inc;

  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    id_d    = id_q;
    xor_d   = xor_q;
    chk_d   = chk_q;
    res_o   = '{kind: sfd_pkg::KindNone, default: '0};
    if (byte_i == cfg_i.start_marker) begin
      phase_d = sfd_pkg::PhLen;
      count_d = '0;
      len_d   = '0;
      id_d    = '0;
      xor_d   = '0;
      chk_d   = '0;
    end else begin
      unique case (phase_q)
        sfd_pkg::PhLen: begin
          len_d = byte_i;
          xor_d = byte_i;
          if (byte_i > cfg_i.max_payload) begin
            phase_d            = sfd_pkg::PhIdle;
            res_o.kind         = sfd_pkg::KindReject;
            res_o.frame_length = byte_i;
          end else begin
            phase_d = sfd_pkg::PhId;
          end
        end
        sfd_pkg::PhId: begin
          id_d               = byte_i;
          xor_d              = xor_q ^ byte_i;
          count_d            = '0;
          phase_d            = (len_q == '0) ? sfd_pkg::PhCheck : sfd_pkg::PhPayload;
          res_o.kind         = sfd_pkg::KindHeader;
          res_o.frame_length = len_q;
          res_o.frame_id     = byte_i;
        end
        sfd_pkg::PhPayload: begin
          xor_d   = xor_q ^ byte_i;
          count_d = count_inc;
          if (count_inc >= len_q) begin
            phase_d = sfd_pkg::PhCheck;
          end
          res_o.kind         = sfd_pkg::KindData;
          res_o.data_byte    = byte_i;
          res_o.payload_pos  = count_q;
          res_o.frame_length = len_q;
          res_o.frame_id     = id_q;
        end
        sfd_pkg::PhCheck: begin
          chk_d   = byte_i;
          phase_d = sfd_pkg::PhEnd;
        end
        sfd_pkg::PhEnd: begin
          phase_d = sfd_pkg::PhIdle;
          if ((chk_q == xor_q) && (byte_i == cfg_i.end_marker)) begin
            res_o.kind = sfd_pkg::KindAccept;
          end else begin
            res_o.kind = sfd_pkg::KindReject;
          end
          res_o.frame_length = len_q;
          res_o.frame_id     = id_q;
        end
        default: begin
          phase_d = sfd_pkg::PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfd_pkg::PhIdle;
      count_q <= '0;
      len_q   <= '0;
      id_q    <= '0;
      xor_q   <= '0;
      chk_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      id_q    <= id_d;
      xor_q   <= xor_d;
      chk_q   <= chk_d;
    end
  end

endmodule

`default_nettype wire

### sv/serial_frame_deframer_xor_check.sv
// Serial frame deframer with XOR checksum check.
// Holds the input and result registers and the configuration registers.
// Depends on sfd_pkg, sfd_parser and assert_macros.svh.
//
// Bytes from a serial receiver enter on the s_axis channel, one per beat.
// Each byte yields exactly one result beat on the m_axis channel: tuser
// carries the kind (nothing, header, payload byte, accepted, rejected) and
// tdata carries the payload byte, its position, the frame length and id.
// A frame is start marker, length, id, payload, XOR checksum, end marker.
// The configuration channel writes the start marker (index 0), the end
// marker (index 1) and the largest payload length (index 2); other indexes
// are ignored. Writes are always taken.
// An input beat passes through the input register and then the result
// register before its result beat appears. The block takes one byte per
// clock as long as the result channel keeps up; the parse state update is
// a single short step per byte.
// When the receiver stalls, the result stays in the result register and one
// more byte waits in the input register before s_axis_tready drops.
// Reset empties both registers, loads the default markers and maximum, and
// makes the parser wait for a start marker.
`default_nettype none

module serial_frame_deframer_xor_check (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // rx_byte
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [31:0]                      m_axis_tdata,   // data_byte, payload_pos,
                                                           // frame_length, frame_id
  output logic [2:0]                       m_axis_tuser,   // kind
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i
);

  `include "assert_macros.svh"

  sfd_pkg::cfg_t cfg_q;
  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          out_valid_q;
  sfd_pkg::res_t out_q;
  sfd_pkg::res_t res;
  logic          out_free;
  logic          step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= sfd_pkg::StartMarkerRst;
      cfg_q.end_marker   <= sfd_pkg::EndMarkerRst;
      cfg_q.max_payload  <= sfd_pkg::MaxPayloadRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfd_pkg::RegStartMarker: cfg_q.start_marker <= cfg_data_i;
        sfd_pkg::RegEndMarker:   cfg_q.end_marker   <= cfg_data_i;
        sfd_pkg::RegMaxPayload:  cfg_q.max_payload  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  sfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {out_q.frame_id, out_q.frame_length, out_q.payload_pos,
                          out_q.data_byte};

  `ASSERT_IMPLIES(a_full_blocks_input, clk_i, rst_ni,
                  in_valid_q && out_valid_q && !m_axis_tready, !s_axis_tready)
  `ASSERT_IMPLIES(a_none_is_zero, clk_i, rst_ni,
                  m_axis_tvalid && (m_axis_tuser == sfd_pkg::KindNone), m_axis_tdata == '0)
  `ASSERT_IMPLIES(a_data_only_payload, clk_i, rst_ni,
                  m_axis_tvalid && (m_axis_tuser != sfd_pkg::KindData),
                  m_axis_tdata[15:0] == '0)
  `ASSERT_IMPLIES(a_pos_in_frame, clk_i, rst_ni,
                  m_axis_tvalid && (m_axis_tuser == sfd_pkg::KindData),
                  m_axis_tdata[15:8] < m_axis_tdata[23:16])

endmodule

`default_nettype wire

### tb/serial_frame_deframer_xor_check_tb.sv
// Testbench for serial_frame_deframer_xor_check: drives bytes on s_axis and
// checks every m_axis beat against a scoreboard that parses frames in parallel.
// Depends on sfd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module serial_frame_deframer_xor_check_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBeats = 340;
  localparam int unsigned HoldCycles = 80;
  localparam logic [sfd_pkg::CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  class deframer_board;
    logic [7:0]       start_mark;
    logic [7:0]       end_mark;
    logic [7:0]       max_len;
    sfd_pkg::phase_e  phase;
    logic [7:0]       count;
    logic [7:0]       len_q;
    logic [7:0]       id_q;
    logic [7:0]       xor_q;
    logic [7:0]       chk_q;
    sfd_pkg::res_t    expected_results[$];
    int               errors;

    function new();
      start_mark = sfd_pkg::StartMarkerRst;
      end_mark = sfd_pkg::EndMarkerRst;
      max_len = sfd_pkg::MaxPayloadRst;
      phase = sfd_pkg::PhIdle;
      count = '0;
      len_q = '0;
      id_q = '0;
      xor_q = '0;
      chk_q = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        sfd_pkg::RegStartMarker: start_mark = val;
        sfd_pkg::RegEndMarker:   end_mark = val;
        sfd_pkg::RegMaxPayload:  max_len = val;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      sfd_pkg::res_t r;
      r = '0;
      r.kind = sfd_pkg::KindNone;
      if (b == start_mark) begin
        phase = sfd_pkg::PhLen;
        count = '0;
        len_q = '0;
        id_q = '0;
        xor_q = '0;
        chk_q = '0;
      end else begin
        case (phase)
          sfd_pkg::PhLen: begin
            len_q = b;
            xor_q = b;
            if (b > max_len) begin
              phase = sfd_pkg::PhIdle;
              r.kind = sfd_pkg::KindReject;
              r.frame_length = b;
            end else begin
              phase = sfd_pkg::PhId;
            end
          end
          sfd_pkg::PhId: begin
            id_q = b;
            xor_q = xor_q ^ b;
            count = '0;
            phase = (len_q == 8'd0) ? sfd_pkg::PhCheck : sfd_pkg::PhPayload;
            r.kind = sfd_pkg::KindHeader;
            r.frame_length = len_q;
            r.frame_id = id_q;
          end
          sfd_pkg::PhPayload: begin
            r.kind = sfd_pkg::KindData;
            r.data_byte = b;
            r.payload_pos = count;
            r.frame_length = len_q;
            r.frame_id = id_q;
            xor_q = xor_q ^ b;
            count = count + 8'd1;
            if (count >= len_q) phase = sfd_pkg::PhCheck;
          end
          sfd_pkg::PhCheck: begin
            chk_q = b;
            phase = sfd_pkg::PhEnd;
          end
          sfd_pkg::PhEnd: begin
            r.kind = (chk_q == xor_q && b == end_mark) ? sfd_pkg::KindAccept
                                                       : sfd_pkg::KindReject;
            r.frame_length = len_q;
            r.frame_id = id_q;
            phase = sfd_pkg::PhIdle;
          end
          default: phase = sfd_pkg::PhIdle;
        endcase
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [31:0] d, logic [2:0] u);
      sfd_pkg::res_t e;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d, tdata %h", u, d);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("kind", {5'd0, e.kind}, {5'd0, u});
      compare_field("data_byte", e.data_byte, d[7:0]);
      compare_field("payload_pos", e.payload_pos, d[15:8]);
      compare_field("frame_length", e.frame_length, d[23:16]);
      compare_field("frame_id", e.frame_id, d[31:24]);
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  deframer_board sb;
  int unsigned   cycles;
  int unsigned   phase_beats;
  int unsigned   hold_left;
  bit            hold_req;
  bit            no_idle;

  serial_frame_deframer_xor_check uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    cycles = 0;
    phase_beats = 0;
    hold_left = 0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    sb = new();
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("serial_frame_deframer_xor_check_tb: errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  task automatic send_byte(logic [7:0] b);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
    phase_beats++;
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_other(logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  task automatic random_frame();
    int         sel;
    int         len;
    int         cut;
    int         i;
    int         top;
    logic [7:0] x;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    top = (sb.max_len < 8) ? sb.max_len : 8;
    if (sb.max_len < 255 && $urandom_range(0, 99) < 8) begin
      len = $urandom_range(sb.max_len + 1, 255);
    end else if (sb.max_len >= 200 && $urandom_range(0, 59) == 0) begin
      len = $urandom_range(200, sb.max_len);
    end else begin
      len = $urandom_range(0, top);
    end
    cut = ($urandom_range(0, 99) < 6) ? $urandom_range(0, len + 1) : -1;
    send_byte(sb.start_mark);
    send_byte(len[7:0]);
    if (len > sb.max_len) return;
    x = len[7:0];
    send_byte(8'($urandom_range(0, 255)));
    x = x ^ s_axis_tdata;
    for (i = 0; i < len; i++) begin
      if (i == cut) begin
        send_byte(sb.start_mark);
        return;
      end
      send_byte(pick_other(sb.start_mark));
      x = x ^ s_axis_tdata;
    end
    if (cut == len) begin
      send_byte(sb.start_mark);
      return;
    end
    if ($urandom_range(0, 99) < 15) x = x ^ (8'h01 << $urandom_range(0, 7));
    send_byte(x);
    if (cut == len + 1) send_byte(sb.start_mark);
    else if ($urandom_range(0, 99) < 15) send_byte(pick_other(sb.end_mark));
    else send_byte(sb.end_mark);
  endtask

  initial begin
    logic [7:0] directed[$];
    logic [7:0] starts[5];
    logic [7:0] ends[5];
    logic [7:0] maxes[5];
    bit         held;
    bit         paused;
    int         p;
    directed = '{8'h00, 8'hFF,
                 8'hAA, 8'h02, 8'h5C, 8'h00, 8'hFF, 8'hA1, 8'hBB,
                 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'hAA, 8'h01, 8'h33, 8'hAA, 8'h00, 8'h7E, 8'h7E, 8'hBB,
                 8'hAA, 8'h01, 8'h11, 8'h22, 8'h00, 8'hBB};
    starts = '{8'hAA, 8'hFF, 8'h00, 8'h5A, 8'h00};
    ends = '{8'hBB, 8'h00, 8'hFF, 8'h5A, 8'h00};
    maxes = '{8'hFF, 8'h00, 8'hFF, 8'h14, 8'h00};
    starts[4] = 8'($urandom_range(0, 255));
    ends[4] = 8'($urandom_range(0, 255));
    maxes[4] = 8'($urandom_range(4, 40));
    held = 1'b0;
    paused = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[k]) send_byte(directed[k]);
    drain();

    for (p = 0; p < 5; p++) begin
      write_cfg(sfd_pkg::RegStartMarker, starts[p]);
      write_cfg(sfd_pkg::RegEndMarker, ends[p]);
      write_cfg(sfd_pkg::RegMaxPayload, maxes[p]);
      if (p == 0) write_cfg(CfgIdxUnused, 8'($urandom_range(0, 255)));
      phase_beats = 0;
      while (phase_beats < PhaseBeats) begin
        no_idle = (p == 2) && (phase_beats < 170);
        if (p == 0 && !held && phase_beats >= 120) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (p == 3 && !paused && phase_beats >= 150) begin
          paused = 1'b1;
          drain();
        end
        random_frame();
      end
      no_idle = 1'b0;
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("serial_frame_deframer_xor_check_tb: clean");
    end else begin
      $display("serial_frame_deframer_xor_check_tb: errors");
    end
    $finish;
  end

endmodule
